/* rtl/core/stok_pkg.sv */
// Shared types, token codes and byte classification for the source tokenizer.
`timescale 1ns / 1ps

package stok_pkg;

  // Widths of the position counter and the keyword capture window
  localparam int POS_BITS    = 16;
  localparam int LEN_BITS    = 8;
  localparam int KW_MAX_LEN  = 6;
  localparam int KW_BITS     = 8 * KW_MAX_LEN;
  localparam int KW_COUNT    = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef logic [4:0] kind_t;

  // Token kinds
  localparam kind_t KIND_NEWLINE   = 5'd0;
  localparam kind_t KIND_EQUAL     = 5'd1;
  localparam kind_t KIND_PLUS      = 5'd2;
  localparam kind_t KIND_MINUS     = 5'd3;
  localparam kind_t KIND_STAR      = 5'd4;
  localparam kind_t KIND_SLASH     = 5'd5;
  localparam kind_t KIND_BACKSLASH = 5'd6;
  localparam kind_t KIND_LPAREN    = 5'd7;
  localparam kind_t KIND_RPAREN    = 5'd8;
  localparam kind_t KIND_LBRACE    = 5'd9;
  localparam kind_t KIND_RBRACE    = 5'd10;
  localparam kind_t KIND_LESS      = 5'd11;
  localparam kind_t KIND_GREATER   = 5'd12;
  localparam kind_t KIND_COLON     = 5'd13;
  localparam kind_t KIND_NUMBER    = 5'd14;
  localparam kind_t KIND_IDENT     = 5'd15;
  localparam kind_t KIND_KW_FIRST  = 5'd16;
  localparam kind_t KIND_END       = 5'd23;

  // Keywords packed oldest byte highest: def pass class return yield async await
  localparam logic [KW_BITS-1:0] KW_TABLE [KW_COUNT] = '{
    KW_BITS'(64'h646566),
    KW_BITS'(64'h70617373),
    KW_BITS'(64'h636C617373),
    KW_BITS'(64'h72657475726E),
    KW_BITS'(64'h7969656C64),
    KW_BITS'(64'h6173796E63),
    KW_BITS'(64'h6177616974)
  };

  // One queued result
  typedef struct packed {
    kind_t               kind;
    logic [POS_BITS-1:0] start;
    logic [LEN_BITS-1:0] length;
    logic                last;
  } token_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  // Letter or underscore
  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
           (b == 8'h5F);
  endfunction

  // Newline and the one-byte symbols
  function automatic logic is_single(input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    case (b) inside
      8'h0A, 8'h3D, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5C, 8'h28, 8'h29,
      8'h7B, 8'h7D, 8'h3C, 8'h3E, 8'h3A: hit = 1'b1;
      default:                           hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic kind_t single_kind(input logic [7:0] b);
    kind_t k;
    k = KIND_NEWLINE;
    case (b)
      8'h3D:   k = KIND_EQUAL;     // =
      8'h2B:   k = KIND_PLUS;      // +
      8'h2D:   k = KIND_MINUS;     // -
      8'h2A:   k = KIND_STAR;      // *
      8'h2F:   k = KIND_SLASH;     // /
      8'h5C:   k = KIND_BACKSLASH; // backslash
      8'h28:   k = KIND_LPAREN;    // (
      8'h29:   k = KIND_RPAREN;    // )
      8'h7B:   k = KIND_LBRACE;    // {
      8'h7D:   k = KIND_RBRACE;    // }
      8'h3C:   k = KIND_LESS;      // <
      8'h3E:   k = KIND_GREATER;   // >
      8'h3A:   k = KIND_COLON;     // :
      default: k = KIND_NEWLINE;
    endcase
    return k;
  endfunction

  // Match the capture window against the keyword list
  function automatic kind_t keyword_kind(input logic [KW_BITS-1:0] w);
    kind_t k;
    k = KIND_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (w == KW_TABLE[i]) k = KIND_KW_FIRST + kind_t'(i);
    end
    return k;
  endfunction

endpackage

/* rtl/core/stok_queue.sv */
// Small result queue that takes up to two tokens per cycle and hands out one.
`timescale 1ns / 1ps

module stok_queue import stok_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push0,
  input  logic   push1,
  input  token_t tok0,
  input  token_t tok1,
  input  logic   pop,
  output token_t head,
  output logic   not_empty,
  output logic   room2
);

  token_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr;
  logic [QUEUE_AW-1:0]  rd_ptr;
  logic [QUEUE_AW:0]    count;
  logic [QUEUE_AW:0]    count_next;
  logic                 pop_ok;

  assign pop_ok    = pop && not_empty;
  assign not_empty = (count != '0);
  assign room2     = (count <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));
  assign head      = mem[rd_ptr];

  // Track occupancy
  always_comb begin
    count_next = count + (QUEUE_AW + 1)'(push0) + (QUEUE_AW + 1)'(push1)
                 - (QUEUE_AW + 1)'(pop_ok);
  end

  // Write up to two entries
  always_ff @(posedge clk) begin
    if (push0) mem[wr_ptr] <= tok0;
    if (push1) mem[QUEUE_AW'(wr_ptr + 1'b1)] <= tok1;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= QUEUE_AW'(wr_ptr + QUEUE_AW'(push0) + QUEUE_AW'(push1));
      if (pop_ok) rd_ptr <= QUEUE_AW'(rd_ptr + 1'b1);
      count <= count_next;
    end
  end

endmodule

/* rtl/core/source_tokenizer.sv */
// Top level of the byte-serial source tokenizer.
`timescale 1ns / 1ps

// Channel | Handshake            | Payload
// input   | in_valid / in_ready  | data_byte, end_of_input
// output  | out_valid / out_ready| token_kind, token_start, token_length, last_of_run
//
// A byte is classified in the cycle of its transfer; its tokens (zero, one or
// two) are written into a four-entry result queue and leave one per cycle
// while out_ready is high. in_ready is high while the queue has room for two
// tokens, so one byte per cycle is taken as long as the output drains; a byte
// that yields two tokens needs two output transfers. Reset (rst, synchronous)
// clears the open token, the position and the queue. A stalled output fills
// the queue and then lowers in_ready.

module source_tokenizer import stok_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                end_of_input,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [4:0]          token_kind,
  output logic [POS_BITS-1:0] token_start,
  output logic [LEN_BITS-1:0] token_length,
  output logic                last_of_run
);

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_ID   = 2'd2
  } mode_t;

  mode_t               mode,        mode_next;
  logic [POS_BITS-1:0] open_start,  open_start_next;
  logic [LEN_BITS-1:0] open_length, open_length_next;
  logic [KW_BITS-1:0]  window,      window_next;
  logic [POS_BITS-1:0] position,    position_next;

  logic   accept;
  logic   digit, alpha, single;
  logic   mode_num, mode_id;
  logic   cont, closing, second;
  kind_t  close_kind;
  token_t close_tok, second_tok, tok0, tok1, head;
  logic   push0, push1, room2, not_empty;

  assign accept   = in_valid && in_ready;
  assign in_ready = room2;

  // Classify the byte against the open token
  always_comb begin
    digit    = is_digit(data_byte);
    alpha    = is_alpha(data_byte);
    single   = is_single(data_byte);
    mode_num = (mode == MODE_NUM);
    mode_id  = (mode == MODE_ID);
    cont     = !end_of_input && ((mode_id && (alpha || digit)) || (mode_num && digit));
    closing  = (mode_num || mode_id) && !cont;
    second   = end_of_input || single;

    if (mode_num) close_kind = KIND_NUMBER;
    else if (open_length <= LEN_BITS'(KW_MAX_LEN)) close_kind = keyword_kind(window);
    else close_kind = KIND_IDENT;
  end

  // Build the tokens for this transfer
  always_comb begin
    close_tok.kind   = close_kind;
    close_tok.start  = open_start;
    close_tok.length = open_length;
    close_tok.last   = !second;

    second_tok.kind   = end_of_input ? KIND_END : single_kind(data_byte);
    second_tok.start  = position;
    second_tok.length = end_of_input ? '0 : LEN_BITS'(1);
    second_tok.last   = 1'b1;

    tok0  = closing ? close_tok : second_tok;
    tok1  = second_tok;
    push0 = accept && (closing || second);
    push1 = accept && closing && second;
  end

  // Update the open token and the position
  always_comb begin
    mode_next        = mode;
    open_start_next  = open_start;
    open_length_next = open_length;
    window_next      = window;
    position_next    = position;
    if (accept) begin
      if (end_of_input) begin
        mode_next        = MODE_NONE;
        open_length_next = '0;
        window_next      = '0;
      end else begin
        position_next = POS_BITS'(position + 1'b1);
        if (cont) begin
          if (mode_id && (open_length < LEN_BITS'(KW_MAX_LEN))) begin
            window_next = {window[KW_BITS-9:0], data_byte};
          end
          if (open_length != '1) open_length_next = LEN_BITS'(open_length + 1'b1);
        end else begin
          mode_next        = MODE_NONE;
          open_length_next = '0;
          window_next      = '0;
          if (digit || alpha) begin
            mode_next        = digit ? MODE_NUM : MODE_ID;
            open_start_next  = position;
            open_length_next = LEN_BITS'(1);
            window_next      = digit ? '0 : KW_BITS'(data_byte);
          end
        end
      end
    end
  end

  // Hold lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NONE;
      open_start  <= '0;
      open_length <= '0;
      window      <= '0;
      position    <= '0;
    end else begin
      mode        <= mode_next;
      open_start  <= open_start_next;
      open_length <= open_length_next;
      window      <= window_next;
      position    <= position_next;
    end
  end

  stok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .push1     (push1),
    .tok0      (tok0),
    .tok1      (tok1),
    .pop       (out_ready),
    .head      (head),
    .not_empty (not_empty),
    .room2     (room2)
  );

  // Drive the output channel from the queue head
  assign out_valid    = not_empty;
  assign token_kind   = head.kind;
  assign token_start  = head.start;
  assign token_length = head.length;
  assign last_of_run  = head.last;

endmodule
